// ===== design/fdcr_pkg.sv =====
// shared types and constants of the framed duty command receiver
`default_nettype none
package fdcr_pkg;

    localparam int unsigned FRAME_BYTES = 8;
    localparam int unsigned POS_W       = 4;

    localparam logic [7:0]  HDR_BYTE  = 8'h02;
    localparam logic [7:0]  TAIL_BYTE = 8'h03;

    localparam logic [14:0] DUTY_MAX_RESET = 15'd3000;
    localparam logic [31:0] TIMEOUT_RESET  = 32'd50000;

    localparam logic [0:0]  REG_DUTY_MAX   = 1'b0;
    localparam logic [0:0]  REG_TIMEOUT_MS = 1'b1;

    localparam logic        CMD_BYTE = 1'b0;
    localparam logic        CMD_TICK = 1'b1;

    typedef struct packed {
        logic        done;
        logic        ok;
        logic [15:0] duty_raw;
    } t_frame_evt;

    typedef struct packed {
        logic [14:0] duty;
        logic        frame_done;
        logic        frame_ok;
        logic        timed_out;
        logic        activity_led;
    } t_result;

endpackage
`default_nettype wire

// ===== design/fdcr_frame_parser.sv =====
// byte position tracking, running xor and frame checks
`default_nettype none
module fdcr_frame_parser (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_accept,
    input  wire               i_cmd,
    input  wire               i_frame_start,
    input  wire  [7:0]        i_rx_byte,
    output fdcr_pkg::t_frame_evt o_evt
);

    localparam logic [fdcr_pkg::POS_W-1:0] POS_IDLE =
        fdcr_pkg::POS_W'(fdcr_pkg::FRAME_BYTES);
    localparam logic [fdcr_pkg::POS_W-1:0] POS_CHECK =
        fdcr_pkg::POS_W'(fdcr_pkg::FRAME_BYTES - 2);
    localparam logic [fdcr_pkg::POS_W-1:0] POS_TAIL =
        fdcr_pkg::POS_W'(fdcr_pkg::FRAME_BYTES - 1);

    logic [fdcr_pkg::POS_W-1:0] r_pos, n_pos;
    logic [7:0] r_xor, n_xor;
    logic       r_hdr_ok, n_hdr_ok;
    logic [7:0] r_lo, n_lo;
    logic [7:0] r_hi, n_hi;
    logic [7:0] r_check, n_check;

    logic [fdcr_pkg::POS_W-1:0] pos_eff;
    logic [7:0] xor_eff;
    logic       hdr_eff;

    always_comb begin
        pos_eff  = i_frame_start ? '0 : r_pos;
        xor_eff  = i_frame_start ? 8'h00 : r_xor;
        hdr_eff  = i_frame_start ? 1'b0 : r_hdr_ok;
        n_pos    = r_pos;
        n_xor    = r_xor;
        n_hdr_ok = r_hdr_ok;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_check  = r_check;
        o_evt    = '{done: 1'b0, ok: 1'b0, duty_raw: {r_hi, r_lo}};
        if (i_accept && i_cmd == fdcr_pkg::CMD_BYTE) begin
            n_pos    = pos_eff;
            n_xor    = xor_eff;
            n_hdr_ok = hdr_eff;
            if (pos_eff < POS_IDLE) begin
                case (pos_eff)
                    4'd0: begin
                        n_hdr_ok = (i_rx_byte == fdcr_pkg::HDR_BYTE);
                    end
                    4'd1: begin
                        n_lo = i_rx_byte;
                    end
                    4'd2: begin
                        n_hi = i_rx_byte;
                    end
                    default: begin
                    end
                endcase
                if (pos_eff < POS_CHECK) begin
                    n_xor = xor_eff ^ i_rx_byte;
                end else if (pos_eff == POS_CHECK) begin
                    n_check = i_rx_byte;
                end else if (pos_eff == POS_TAIL) begin
                    o_evt.done = 1'b1;
                    o_evt.ok   = hdr_eff && (i_rx_byte == fdcr_pkg::TAIL_BYTE)
                                 && (xor_eff == r_check);
                end
                n_pos = pos_eff + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= POS_IDLE;
            r_xor    <= 8'h00;
            r_hdr_ok <= 1'b0;
            r_lo     <= 8'h00;
            r_hi     <= 8'h00;
            r_check  <= 8'h00;
        end else begin
            r_pos    <= n_pos;
            r_xor    <= n_xor;
            r_hdr_ok <= n_hdr_ok;
            r_lo     <= n_lo;
            r_hi     <= n_hi;
            r_check  <= n_check;
        end
    end

endmodule
`default_nettype wire

// ===== design/fdcr_duty_ctrl.sv =====
// duty clamp, silence counter, timeout and activity flag
`default_nettype none
module fdcr_duty_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_accept,
    input  wire                  i_cmd,
    input  fdcr_pkg::t_frame_evt i_evt,
    input  wire  [14:0]          i_duty_max,
    input  wire  [31:0]          i_timeout_ms,
    output fdcr_pkg::t_result    o_result
);

    logic [14:0] r_duty, n_duty;
    logic [31:0] r_silence, n_silence;
    logic        r_led, n_led;
    logic [14:0] clamped;
    logic        tmo;

    always_comb begin
        if (i_evt.duty_raw[15]) begin
            clamped = 15'd0;
        end else if (i_evt.duty_raw[14:0] > i_duty_max) begin
            clamped = i_duty_max;
        end else begin
            clamped = i_evt.duty_raw[14:0];
        end
    end

    always_comb begin
        n_duty    = r_duty;
        n_silence = r_silence;
        n_led     = r_led;
        if (i_accept) begin
            if (i_cmd == fdcr_pkg::CMD_TICK) begin
                if (r_silence != 32'hFFFF_FFFF) begin
                    n_silence = r_silence + 32'd1;
                end
            end else if (i_evt.done) begin
                n_silence = 32'd0;
                n_led     = ~r_led;
                if (i_evt.ok) begin
                    n_duty = clamped;
                end
            end
        end
        tmo = (n_silence > i_timeout_ms);
        if (tmo) begin
            n_duty = 15'd0;
        end
        o_result = '{duty: n_duty, frame_done: i_evt.done, frame_ok: i_evt.ok,
                     timed_out: tmo, activity_led: n_led};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty    <= 15'd0;
            r_silence <= 32'd0;
            r_led     <= 1'b0;
        end else if (i_accept) begin
            r_duty    <= n_duty;
            r_silence <= n_silence;
            r_led     <= n_led;
        end
    end

endmodule
`default_nettype wire

// ===== design/framed_duty_command_receiver_top.sv =====
// top level of the framed duty command receiver
// Takes one transfer per cycle: a link byte (tuser cmd 0) or a millisecond
// tick (tuser cmd 1), and returns one result transfer for each. Eight-byte
// frames (header, duty low, duty high, status, sequence, reserved, xor check,
// tail) load a clamped duty when valid; ticks advance a saturating silence
// counter that forces duty to zero once it exceeds timeout_ms. Each result appears
// in the cycle after its input transfer; all per-item work sits between the
// input handshake and the output register, so the sustained rate is one item
// per cycle while the output side keeps taking results. Configuration writes
// take effect on the next cycle and belong in idle periods.
`default_nettype none
module framed_duty_command_receiver_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // rx_byte
    input  wire  [1:0]  i_s_axis_tuser,   // cmd, frame_start
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // duty[14:0], timed_out, activity_led, zero fill
    output logic        o_m_axis_tlast,   // frame_done
    output logic        o_m_axis_tuser,   // frame_ok
    input  wire         i_cfg_we,
    input  wire  [0:0]  i_cfg_addr,
    input  wire  [31:0] i_cfg_wdata
);

    logic [14:0] r_duty_max;
    logic [31:0] r_timeout_ms;
    logic        r_out_valid;
    fdcr_pkg::t_result r_out, n_out;
    fdcr_pkg::t_frame_evt evt;
    logic        accept;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_max   <= fdcr_pkg::DUTY_MAX_RESET;
            r_timeout_ms <= fdcr_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                fdcr_pkg::REG_DUTY_MAX:   r_duty_max   <= i_cfg_wdata[14:0];
                fdcr_pkg::REG_TIMEOUT_MS: r_timeout_ms <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    fdcr_frame_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_cmd         (i_s_axis_tuser[0]),
        .i_frame_start (i_s_axis_tuser[1]),
        .i_rx_byte     (i_s_axis_tdata),
        .o_evt         (evt)
    );

    fdcr_duty_ctrl u_duty (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_cmd        (i_s_axis_tuser[0]),
        .i_evt        (evt),
        .i_duty_max   (r_duty_max),
        .i_timeout_ms (r_timeout_ms),
        .o_result     (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out.activity_led, r_out.timed_out, r_out.duty};
    assign o_m_axis_tlast  = r_out.frame_done;
    assign o_m_axis_tuser  = r_out.frame_ok;

endmodule
`default_nettype wire
